// ===== hw/rtl/ffp_pkg.sv =====
// ----------------------------------------------------------------------------
// ffp_pkg: shared types and constants of the frame fragment packetizer
// Header layout constants, the per-item decision record and the header
// byte lookup used by the output sequencer.
// ----------------------------------------------------------------------------
package ffp_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned FLEN_W   = 24;
  localparam int unsigned PLEN_W   = 16;
  localparam int unsigned HDR_LEN  = 32;
  localparam int unsigned HIDX_W   = $clog2(HDR_LEN);

  localparam logic [PLEN_W-1:0] MAX_PAYLOAD_RST = 16'd1200;

  // Fixed header byte values
  localparam logic [BYTE_W-1:0] DATA_HDR_ID    = 8'h82;
  localparam logic [BYTE_W-1:0] DATA_HDR_FLAGS = 8'h01;
  localparam logic [BYTE_W-1:0] DATA_HDR_PROP  = 8'h7D;
  localparam logic [BYTE_W-1:0] PAY_HDR_ID     = 8'h81;

  // Header byte positions (fields are big-endian)
  localparam logic [HIDX_W-1:0] POS_DATA_ID  = 5'd0;
  localparam logic [HIDX_W-1:0] POS_FLAGS    = 5'd3;
  localparam logic [HIDX_W-1:0] POS_PROP     = 5'd4;
  localparam logic [HIDX_W-1:0] POS_PAY_ID   = 5'd12;
  localparam logic [HIDX_W-1:0] POS_OFF_B2   = 5'd18;
  localparam logic [HIDX_W-1:0] POS_OFF_B1   = 5'd19;
  localparam logic [HIDX_W-1:0] POS_OFF_B0   = 5'd20;
  localparam logic [HIDX_W-1:0] POS_SIZE_B2  = 5'd23;
  localparam logic [HIDX_W-1:0] POS_SIZE_B1  = 5'd24;
  localparam logic [HIDX_W-1:0] POS_SIZE_B0  = 5'd25;
  localparam logic [HIDX_W-1:0] POS_PLEN_B1  = 5'd30;
  localparam logic [HIDX_W-1:0] POS_PLEN_B0  = 5'd31;
  localparam logic [HIDX_W-1:0] POS_LAST     = 5'd31;

  // What the frame tracker decided for the item at the input
  typedef struct packed {
    logic              drop;    // empty frame, item produces nothing
    logic              open;    // item opens a packet, header goes first
    logic [PLEN_W-1:0] plen;    // payload length of the opening packet
    logic [FLEN_W-1:0] offset;  // frame offset of this item
    logic [FLEN_W-1:0] size;    // latched frame size
    logic              pend;    // last byte of its packet
    logic              fend;    // last byte of the frame
  } ffp_dec_t;

  function automatic logic [BYTE_W-1:0] hdr_byte(
    input logic [HIDX_W-1:0] idx,
    input logic [FLEN_W-1:0] off,
    input logic [FLEN_W-1:0] size,
    input logic [PLEN_W-1:0] plen
  );
    logic [BYTE_W-1:0] b;
    case (idx)
      POS_DATA_ID: b = DATA_HDR_ID;
      POS_FLAGS:   b = DATA_HDR_FLAGS;
      POS_PROP:    b = DATA_HDR_PROP;
      POS_PAY_ID:  b = PAY_HDR_ID;
      POS_OFF_B2:  b = off[23:16];
      POS_OFF_B1:  b = off[15:8];
      POS_OFF_B0:  b = off[7:0];
      POS_SIZE_B2: b = size[23:16];
      POS_SIZE_B1: b = size[15:8];
      POS_SIZE_B0: b = size[7:0];
      POS_PLEN_B1: b = plen[15:8];
      POS_PLEN_B0: b = plen[7:0];
      default:     b = '0;
    endcase
    return b;
  endfunction

endpackage

// ===== hw/rtl/ffp_if.sv =====
// ----------------------------------------------------------------------------
// ffp_if: stream channels of the frame fragment packetizer
// Valid/ready channels for frame bytes in and packet stream bytes out.
// ----------------------------------------------------------------------------
interface ffp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [23:0] frame_length;

  modport source (output valid, output data_byte, output frame_length, input ready);
  modport sink   (input valid, input data_byte, input frame_length, output ready);
endinterface

interface ffp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       packet_end;
  logic       frame_end;

  modport source (output valid, output out_byte, output packet_end, output frame_end,
                  input ready);
  modport sink   (input valid, input out_byte, input packet_end, input frame_end,
                  output ready);
endinterface

// ===== hw/rtl/ffp_frame_tracker.sv =====
// ----------------------------------------------------------------------------
// ffp_frame_tracker: frame and packet position bookkeeping
// Holds the frame offset, latched size, packet byte budget and the
// max_payload register; decides per item whether a packet opens.
// ----------------------------------------------------------------------------
module ffp_frame_tracker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [15:0]               cfg_wdata,
  input  logic                      accept,
  input  logic [23:0]               frame_length,
  output ffp_pkg::ffp_dec_t         dec
);
  import ffp_pkg::*;

  logic [PLEN_W-1:0] max_payload_r;
  logic [FLEN_W-1:0] offset_r, offset_nxt;
  logic [FLEN_W-1:0] size_r,   size_nxt;
  logic [PLEN_W-1:0] left_r,   left_nxt;
  logic              inside_r, inside_nxt;

  logic [FLEN_W-1:0] off_c, size_c, remain, off_inc;
  logic [PLEN_W-1:0] left_c, limit, plen, left_after;

  always_comb begin
    // A frame's first byte starts from a clean position
    off_c  = inside_r ? offset_r : '0;
    size_c = inside_r ? size_r   : frame_length;
    left_c = inside_r ? left_r   : '0;

    limit  = (max_payload_r == '0) ? PLEN_W'(1) : max_payload_r;
    remain = size_c - off_c;
    plen   = (remain < FLEN_W'(limit)) ? remain[PLEN_W-1:0] : limit;

    left_after = ((left_c == '0) ? plen : left_c) - PLEN_W'(1);
    off_inc    = off_c + FLEN_W'(1);

    dec.drop   = !inside_r && (frame_length == '0);
    dec.open   = (left_c == '0);
    dec.plen   = plen;
    dec.offset = off_c;
    dec.size   = size_c;
    dec.pend   = (left_after == '0);
    dec.fend   = (off_inc >= size_c);

    offset_nxt = offset_r;
    size_nxt   = size_r;
    left_nxt   = left_r;
    inside_nxt = inside_r;
    if (accept && !dec.drop) begin
      offset_nxt = off_inc;
      size_nxt   = size_c;
      left_nxt   = dec.fend ? '0 : left_after;
      inside_nxt = !dec.fend;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= MAX_PAYLOAD_RST;
      offset_r      <= '0;
      size_r        <= '0;
      left_r        <= '0;
      inside_r      <= 1'b0;
    end else begin
      if (cfg_we) max_payload_r <= cfg_wdata;
      offset_r <= offset_nxt;
      size_r   <= size_nxt;
      left_r   <= left_nxt;
      inside_r <= inside_nxt;
    end
  end

endmodule

// ===== hw/rtl/frame_fragment_packetizer.sv =====
// ----------------------------------------------------------------------------
// frame_fragment_packetizer: cuts media frames into headed packets
// Byte-serial frame in, byte-serial packet stream out, 32-byte header
// in front of every packet.
// ----------------------------------------------------------------------------
// Output is registered: an accepted item's first output byte appears in the cycle after it is accepted.
// Throughput: payload items pass at 1 item per cycle while the output takes bytes. An item that opens a
//   packet yields 33 output bytes; the header sequencer holds the input off
//   while the header bytes occupy the output register.
// Reset: synchronous active-low rst_n; clears the frame position, output
//   valid and header sequencer, and loads max_payload with 1200.
// ----------------------------------------------------------------------------
module frame_fragment_packetizer (
  input  logic         clk,
  input  logic         rst_n,
  ffp_in_if.sink       in_s,
  ffp_out_if.source    out_m,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata
);
  import ffp_pkg::*;

  ffp_dec_t dec;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r,  out_byte_nxt;
  logic              out_pend_r,  out_pend_nxt;
  logic              out_fend_r,  out_fend_nxt;

  // Header sequencer: header fields and the payload byte parked behind them
  logic              hdr_busy_r,  hdr_busy_nxt;
  logic [HIDX_W-1:0] hdr_idx_r,   hdr_idx_nxt;
  logic [FLEN_W-1:0] hdr_off_r,   hdr_off_nxt;
  logic [FLEN_W-1:0] hdr_size_r,  hdr_size_nxt;
  logic [PLEN_W-1:0] hdr_plen_r,  hdr_plen_nxt;
  logic [BYTE_W-1:0] pay_byte_r,  pay_byte_nxt;
  logic              pay_pend_r,  pay_pend_nxt;
  logic              pay_fend_r,  pay_fend_nxt;

  logic slot_free, in_acc;

  // Output slot frees when empty or when its byte is taken this cycle
  assign slot_free  = !out_valid_r || out_m.ready;
  assign in_s.ready = !hdr_busy_r && slot_free;
  assign in_acc     = in_s.valid && in_s.ready;

  ffp_frame_tracker u_tracker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .accept       (in_acc),
    .frame_length (in_s.frame_length),
    .dec          (dec)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_pend_nxt  = out_pend_r;
    out_fend_nxt  = out_fend_r;
    hdr_busy_nxt  = hdr_busy_r;
    hdr_idx_nxt   = hdr_idx_r;
    hdr_off_nxt   = hdr_off_r;
    hdr_size_nxt  = hdr_size_r;
    hdr_plen_nxt  = hdr_plen_r;
    pay_byte_nxt  = pay_byte_r;
    pay_pend_nxt  = pay_pend_r;
    pay_fend_nxt  = pay_fend_r;

    if (slot_free) begin
      if (hdr_busy_r) begin
        // Step through the header; the parked payload byte follows the last
        if (hdr_idx_r == POS_LAST) begin
          out_byte_nxt = pay_byte_r;
          out_pend_nxt = pay_pend_r;
          out_fend_nxt = pay_fend_r;
          hdr_busy_nxt = 1'b0;
        end else begin
          hdr_idx_nxt  = hdr_idx_r + HIDX_W'(1);
          out_byte_nxt = hdr_byte(hdr_idx_r + HIDX_W'(1), hdr_off_r, hdr_size_r,
                                  hdr_plen_r);
          out_pend_nxt = 1'b0;
          out_fend_nxt = 1'b0;
        end
        out_valid_nxt = 1'b1;
      end else if (in_acc && !dec.drop) begin
        out_valid_nxt = 1'b1;
        if (dec.open) begin
          // Packet opens: first header byte now, payload byte parked
          hdr_busy_nxt = 1'b1;
          hdr_idx_nxt  = POS_DATA_ID;
          hdr_off_nxt  = dec.offset;
          hdr_size_nxt = dec.size;
          hdr_plen_nxt = dec.plen;
          pay_byte_nxt = in_s.data_byte;
          pay_pend_nxt = dec.pend;
          pay_fend_nxt = dec.fend;
          out_byte_nxt = hdr_byte(POS_DATA_ID, dec.offset, dec.size, dec.plen);
          out_pend_nxt = 1'b0;
          out_fend_nxt = 1'b0;
        end else begin
          out_byte_nxt = in_s.data_byte;
          out_pend_nxt = dec.pend;
          out_fend_nxt = dec.fend;
        end
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      hdr_busy_r  <= 1'b0;
      hdr_idx_r   <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      hdr_busy_r  <= hdr_busy_nxt;
      hdr_idx_r   <= hdr_idx_nxt;
    end
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_pend_r <= out_pend_nxt;
    out_fend_r <= out_fend_nxt;
    hdr_off_r  <= hdr_off_nxt;
    hdr_size_r <= hdr_size_nxt;
    hdr_plen_r <= hdr_plen_nxt;
    pay_byte_r <= pay_byte_nxt;
    pay_pend_r <= pay_pend_nxt;
    pay_fend_r <= pay_fend_nxt;
  end

  assign out_m.valid      = out_valid_r;
  assign out_m.out_byte   = out_byte_r;
  assign out_m.packet_end = out_pend_r;
  assign out_m.frame_end  = out_fend_r;

  // Input is held off while header bytes are being sent
  a_busy_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_busy_r |-> !in_s.ready)
    else $error("input accepted during header");

  // Header bytes never carry end flags
  a_hdr_no_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && hdr_busy_r) |-> (!out_pend_r && !out_fend_r))
    else $error("end flag on header byte");

  // The frame's last byte also closes its packet
  a_fend_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_fend_r) |-> out_pend_r)
    else $error("frame end without packet end");

  // An opening item starts the header sequence
  a_open_starts_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !dec.drop && dec.open) |=> (hdr_busy_r && hdr_idx_r == POS_DATA_ID))
    else $error("header sequence not started");

endmodule
